// ===== rtl/fna_pkg.sv =====
// shared types and constants of the face normal accumulator
package fna_pkg;

   localparam int FNA_VERTEX_COUNT = 1024;
   localparam int FNA_SUM_WIDTH    = 24;
   localparam int IDX_W            = 10;
   localparam int COORD_W          = 16;
   localparam int RSP_SUM_W        = 24;
   localparam int UNIT_W           = 16;

   // one triangle
   typedef struct packed {
      logic [IDX_W-1:0]          first_index;
      logic [IDX_W-1:0]          second_index;
      logic [IDX_W-1:0]          third_index;
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] first_z;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic signed [COORD_W-1:0] second_z;
      logic signed [COORD_W-1:0] third_x;
      logic signed [COORD_W-1:0] third_y;
      logic signed [COORD_W-1:0] third_z;
   } req_type;

   // one vertex update
   typedef struct packed {
      logic [IDX_W-1:0]            vertex_index;
      logic signed [RSP_SUM_W-1:0] sum_x;
      logic signed [RSP_SUM_W-1:0] sum_y;
      logic signed [RSP_SUM_W-1:0] sum_z;
      logic                        last;
   } rsp_type;

   // unit normal and the three indices, handed from front to back
   typedef struct packed {
      logic [IDX_W-1:0]         idx0;
      logic [IDX_W-1:0]         idx1;
      logic [IDX_W-1:0]         idx2;
      logic signed [UNIT_W-1:0] unit_x;
      logic signed [UNIT_W-1:0] unit_y;
      logic signed [UNIT_W-1:0] unit_z;
   } job_type;

endpackage

// ===== rtl/fna_front.sv =====
// front end: newell normal, square root and divide to a q1.14 unit vector
module fna_front import fna_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    front_busy,
   input  logic    queue_full,
   output logic    push,
   output job_type push_data
);

   typedef enum logic [2:0] {
      F_IDLE, F_NEWELL, F_NORM, F_SQUARE, F_SQRT, F_DSET, F_DIV, F_PUSH
   } state_type;

   state_type            state_ff;
   logic [4:0]           cnt_ff;
   req_type              req_ff;
   logic signed [33:0]   px_ff, py_ff, pz_ff;
   logic signed [35:0]   mx_ff, my_ff, mz_ff;
   logic [30:0]          a_ff [3];
   logic [2:0]           neg_ff;
   logic [61:0]          sq_ff;
   logic [63:0]          s_ff;
   logic [32:0]          rem_ff;
   logic [31:0]          root_ff;
   logic [31:0]          drem_ff [3];
   logic [14:0]          dlow_ff [3];
   logic [14:0]          q_ff [3];
   logic                 zero_ff;

   // corner pair of the current edge
   logic signed [COORD_W-1:0] xi, yi, zi, xj, yj, zj;
   always_comb begin
      case (cnt_ff[1:0])
         2'd0: begin
            xi = req_ff.first_x;  yi = req_ff.first_y;  zi = req_ff.first_z;
            xj = req_ff.second_x; yj = req_ff.second_y; zj = req_ff.second_z;
         end
         2'd1: begin
            xi = req_ff.second_x; yi = req_ff.second_y; zi = req_ff.second_z;
            xj = req_ff.third_x;  yj = req_ff.third_y;  zj = req_ff.third_z;
         end
         default: begin
            xi = req_ff.third_x;  yi = req_ff.third_y;  zi = req_ff.third_z;
            xj = req_ff.first_x;  yj = req_ff.first_y;  zj = req_ff.first_z;
         end
      endcase
   end

   // edge products
   logic signed [16:0] dx, dy, dz, sx, sy, sz;
   logic signed [33:0] px_in, py_in, pz_in;
   assign dx = 17'(xi) - 17'(xj);
   assign dy = 17'(yi) - 17'(yj);
   assign dz = 17'(zi) - 17'(zj);
   assign sx = 17'(xi) + 17'(xj);
   assign sy = 17'(yi) + 17'(yj);
   assign sz = 17'(zi) + 17'(zj);
   assign px_in = 34'(dy) * 34'(sz);
   assign py_in = 34'(dz) * 34'(sx);
   assign pz_in = 34'(dx) * 34'(sy);

   // magnitudes and the common right shift that brings them under 2^31
   logic [35:0] mag [3];
   logic [35:0] mag_or;
   logic [2:0]  shift;
   assign mag[0] = mx_ff[35] ? 36'(-mx_ff) : 36'(mx_ff);
   assign mag[1] = my_ff[35] ? 36'(-my_ff) : 36'(my_ff);
   assign mag[2] = mz_ff[35] ? 36'(-mz_ff) : 36'(mz_ff);
   assign mag_or = mag[0] | mag[1] | mag[2];
   always_comb begin
      if (mag_or[35])      shift = 3'd5;
      else if (mag_or[34]) shift = 3'd4;
      else if (mag_or[33]) shift = 3'd3;
      else if (mag_or[32]) shift = 3'd2;
      else if (mag_or[31]) shift = 3'd1;
      else                 shift = 3'd0;
   end

   // component to square this cycle
   logic [30:0] a_sel;
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    a_sel = a_ff[0];
         2'd1:    a_sel = a_ff[1];
         default: a_sel = a_ff[2];
      endcase
   end

   // one digit of the square root
   logic [34:0] sq_rem_t, sq_test;
   assign sq_rem_t = {rem_ff[32:0], s_ff[63:62]};
   assign sq_test  = {1'b0, root_ff, 2'b01};

   // dividend of each component: a * 16384 + floor(l / 2)
   logic [45:0] num [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num[i] = {1'b0, a_ff[i], 14'd0} + 46'(root_ff[31:1]);
      end
   end

   // one quotient bit per component
   logic [32:0] dv_t [3];
   logic        dv_ge [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dv_t[i]  = {drem_ff[i], dlow_ff[i][14]};
         dv_ge[i] = dv_t[i] >= {1'b0, root_ff};
      end
   end

   // signed unit components
   logic signed [UNIT_W-1:0] unit [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (zero_ff) begin
            unit[i] = '0;
         end else if (neg_ff[i]) begin
            unit[i] = -UNIT_W'(q_ff[i]);
         end else begin
            unit[i] = UNIT_W'(q_ff[i]);
         end
      end
   end

   assign front_busy = state_ff != F_IDLE;
   assign push       = state_ff == F_PUSH && !queue_full;
   assign push_data  = '{idx0: req_ff.first_index, idx1: req_ff.second_index,
                         idx2: req_ff.third_index, unit_x: unit[0],
                         unit_y: unit[1], unit_z: unit[2]};

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (start) begin
                  req_ff   <= req_data;
                  mx_ff    <= '0;
                  my_ff    <= '0;
                  mz_ff    <= '0;
                  cnt_ff   <= '0;
                  state_ff <= F_NEWELL;
               end
            end
            F_NEWELL: begin
               if (cnt_ff != 5'd3) begin
                  px_ff <= px_in;
                  py_ff <= py_in;
                  pz_ff <= pz_in;
               end
               if (cnt_ff != 5'd0) begin
                  mx_ff <= mx_ff + 36'(px_ff);
                  my_ff <= my_ff + 36'(py_ff);
                  mz_ff <= mz_ff + 36'(pz_ff);
               end
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd3) begin
                  state_ff <= F_NORM;
               end
            end
            F_NORM: begin
               for (int i = 0; i < 3; i++) begin
                  a_ff[i] <= 31'(mag[i] >> shift);
               end
               neg_ff   <= {mz_ff[35], my_ff[35], mx_ff[35]};
               s_ff     <= '0;
               cnt_ff   <= '0;
               state_ff <= F_SQUARE;
            end
            F_SQUARE: begin
               if (cnt_ff != 5'd3) begin
                  sq_ff <= 62'(a_sel) * 62'(a_sel);
               end
               if (cnt_ff != 5'd0) begin
                  s_ff <= s_ff + 64'(sq_ff);
               end
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd3) begin
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= F_SQRT;
               end
            end
            F_SQRT: begin
               if (sq_rem_t >= sq_test) begin
                  rem_ff  <= 33'(sq_rem_t - sq_test);
                  root_ff <= {root_ff[30:0], 1'b1};
               end else begin
                  rem_ff  <= sq_rem_t[32:0];
                  root_ff <= {root_ff[30:0], 1'b0};
               end
               s_ff   <= {s_ff[61:0], 2'b00};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  state_ff <= F_DSET;
               end
            end
            F_DSET: begin
               for (int i = 0; i < 3; i++) begin
                  drem_ff[i] <= {1'b0, num[i][45:15]};
                  dlow_ff[i] <= num[i][14:0];
                  q_ff[i]    <= '0;
               end
               zero_ff  <= root_ff == '0;
               cnt_ff   <= '0;
               state_ff <= (root_ff == '0) ? F_PUSH : F_DIV;
            end
            F_DIV: begin
               for (int i = 0; i < 3; i++) begin
                  drem_ff[i] <= dv_ge[i] ? 32'(dv_t[i] - {1'b0, root_ff})
                                         : dv_t[i][31:0];
                  dlow_ff[i] <= {dlow_ff[i][13:0], 1'b0};
                  q_ff[i]    <= {q_ff[i][13:0], dv_ge[i]};
               end
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd14) begin
                  state_ff <= F_PUSH;
               end
            end
            F_PUSH: begin
               if (!queue_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/fna_queue.sv =====
// two-entry queue between front and back
module fna_queue import fna_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   output logic    head_valid,
   output job_type head,
   input  logic    pop
);

   job_type    slot_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head       = slot_ff[rd_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   // entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/fna_back.sv =====
// back end: read-modify-write of the per-vertex normal sums
module fna_back import fna_pkg::*; #(
   parameter int VERTEX_COUNT = FNA_VERTEX_COUNT,
   parameter int SUM_WIDTH    = FNA_SUM_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   output logic    pop,
   output logic    clearing,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(VERTEX_COUNT);

   typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_READ, B_UPD} state_type;

   typedef struct packed {
      logic signed [SUM_WIDTH-1:0] x;
      logic signed [SUM_WIDTH-1:0] y;
      logic signed [SUM_WIDTH-1:0] z;
   } sum_type;

   localparam logic signed [SUM_WIDTH:0] SMAX = {2'b00, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH:0] SMIN = {2'b11, {(SUM_WIDTH-1){1'b0}}};

   // index folded into the store by repeated subtraction of scaled counts
   function automatic logic [AW-1:0] fold(input logic [IDX_W-1:0] idx);
      int r;
      r = int'(idx);
      for (int j = IDX_W - 1; j >= 0; j--) begin
         if ((VERTEX_COUNT << j) <= r) begin
            r = r - (VERTEX_COUNT << j);
         end
      end
      return AW'(r);
   endfunction

   function automatic logic signed [SUM_WIDTH-1:0] sat(
      input logic signed [SUM_WIDTH-1:0] a,
      input logic signed [UNIT_W-1:0]    b
   );
      logic signed [SUM_WIDTH:0] s;
      s = (SUM_WIDTH+1)'(a) + (SUM_WIDTH+1)'(b);
      if (s > SMAX) s = SMAX;
      if (s < SMIN) s = SMIN;
      return s[SUM_WIDTH-1:0];
   endfunction

   state_type        state_ff;
   logic [1:0]       vert_ff;
   logic [AW-1:0]    clr_ff;
   sum_type          rd_ff;
   sum_type          mem [VERTEX_COUNT];
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   // current vertex
   logic [IDX_W-1:0] cur_idx;
   logic [AW-1:0]    cur_addr;
   sum_type          upd;
   always_comb begin
      case (vert_ff)
         2'd0:    cur_idx = job.idx0;
         2'd1:    cur_idx = job.idx1;
         default: cur_idx = job.idx2;
      endcase
      cur_addr = fold(cur_idx);
      upd.x = sat(rd_ff.x, job.unit_x);
      upd.y = sat(rd_ff.y, job.unit_y);
      upd.z = sat(rd_ff.z, job.unit_z);
   end

   assign clearing  = state_ff == B_CLEAR;
   assign pop       = state_ff == B_UPD && vert_ff == 2'd2;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         vert_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            B_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(VERTEX_COUNT - 1)) begin
                  state_ff <= B_IDLE;
               end
            end
            B_IDLE: begin
               vert_ff <= '0;
               if (job_valid) begin
                  state_ff <= B_READ;
               end
            end
            B_READ: begin
               state_ff <= B_UPD;
            end
            B_UPD: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff <= '{vertex_index: cur_idx,
                           sum_x: RSP_SUM_W'(upd.x),
                           sum_y: RSP_SUM_W'(upd.y),
                           sum_z: RSP_SUM_W'(upd.z),
                           last: vert_ff == 2'd2};
               if (vert_ff == 2'd2) begin
                  state_ff <= B_IDLE;
               end else begin
                  vert_ff  <= vert_ff + 2'd1;
                  state_ff <= B_READ;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   // normal sum store
   always_ff @(posedge clock) begin
      if (state_ff == B_CLEAR) begin
         mem[clr_ff] <= '0;
      end else if (state_ff == B_UPD) begin
         mem[cur_addr] <= upd;
      end
      rd_ff <= mem[cur_addr];
   end

endmodule

// ===== rtl/face_normal_accumulator.sv =====
// top level of the face normal accumulator
//
//   channel   ports                     direction   handshake
//   triangle  req_data, start, busy     in          start & !busy
//   vertex    rsp_data, rsp_valid       out         rsp_valid, one cycle
//
// the front is busy per triangle through newell steps, a shift, squaring,
// square root digits, a divide set-up, divide steps in three parallel
// dividers and a hand-over that waits while the queue is full; the divide
// is skipped when the normal is zero; a new triangle starts only from idle
// the back handles each triangle with an idle state, then a read and an
// update state per vertex on the store port; each result is registered
// with its store write; after reset a clearing pass over all VERTEX_COUNT
// store entries holds busy high; results cannot be held off; the two-entry
// queue lets the front start the next triangle while the back is still writing
module face_normal_accumulator import fna_pkg::*; #(
   parameter int VERTEX_COUNT = FNA_VERTEX_COUNT,
   parameter int SUM_WIDTH    = FNA_SUM_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic    front_busy, queue_full, push, pop, head_valid, clearing;
   job_type push_data, head;

   assign busy = front_busy || clearing;

   // front end
   fna_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start && !busy),
      .req_data   (req_data),
      .front_busy (front_busy),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // queue
   fna_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   // back end
   fna_back #(
      .VERTEX_COUNT (VERTEX_COUNT),
      .SUM_WIDTH    (SUM_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/fna_checker.sv =====
// port-level checks of the face normal accumulator
module fna_checker import fna_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // clearing pass follows reset
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   // an accepted beat makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("not busy after accepted beat");

   // a vertex update never follows another in the next cycle
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results back to back");

   // the vertices of one triangle come as one run, a read state apart
   a_rsp_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> ##2 rsp_valid)
      else $error("triangle results broken up");

endmodule

bind face_normal_accumulator fna_checker u_fna_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
